/* rtl/tblt_pkg.sv */
package tblt_pkg;

	typedef enum logic [2:0] {
		KIND_INSERT   = 3'd0,
		KIND_LOOKUP   = 3'd1,
		KIND_INV_ALL  = 3'd2,
		KIND_INV_RNG  = 3'd3,
		KIND_FREE     = 3'd4
	} kind_t;

	localparam logic [1:0] RES_HIT       = 2'd0;
	localparam logic [1:0] RES_MISS_STALE = 2'd1;
	localparam logic [1:0] RES_MISS_GEN  = 2'd2;
	localparam logic [1:0] RES_MISS_NONE = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NO_HANDLE = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [31:0] gen;
		logic [15:0] hnd;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  lookup_result;
		logic [15:0] found_handle;
		logic [1:0]  status;
		logic [6:0]  block_count;
	} rsp_t;

endpackage

/* rtl/tblt_front.sv */
module tblt_front #(
	parameter int GEN_BITS    = 32,
	parameter int HANDLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          kind,
	input  logic [63:0]         address_low,
	input  logic [63:0]         address_high,
	input  logic [31:0]         generation,
	input  logic [15:0]         handle,
	output logic                cmd_valid,
	input  logic                cmd_take,
	output tblt_pkg::cmd_t      cmd
);
	import tblt_pkg::*;

	localparam logic [63:0] GEN_MASK = {64{1'b1}} >> (64 - GEN_BITS);
	localparam logic [63:0] HND_MASK = {64{1'b1}} >> (64 - HANDLE_BITS);

	// two-entry command queue
	cmd_t       buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t       in_c;

	always_comb begin
		in_c.kind = kind;
		in_c.lo   = address_low;
		in_c.hi   = address_high;
		in_c.gen  = generation & GEN_MASK[31:0];
		in_c.hnd  = handle & HND_MASK[15:0];
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_q] <= in_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (cmd_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'(cmd_take ? 1 : 0);
		end
	end
endmodule

/* rtl/tblt_back.sv */
module tblt_back #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_take,
	input  tblt_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_take,
	output tblt_pkg::rsp_t rsp
);
	import tblt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_SCAN = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [TABLE_DEPTH-1:0] valid_q, stale_q;
	logic [63:0] start_m [TABLE_DEPTH];
	logic [63:0] end_m   [TABLE_DEPTH];
	logic [31:0] gen_m   [TABLE_DEPTH];
	logic [15:0] id_m    [TABLE_DEPTH];
	logic [31:0] stamp_m [TABLE_DEPTH];
	logic [63:0] rd_start_q, rd_end_q;
	logic [31:0] rd_gen_q, rd_stamp_q;
	logic [15:0] rd_id_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW:0]   idx_q;
	logic [CW-1:0] count_q;
	logic [31:0] ins_cnt_q;
	cmd_t cmd_q;
	logic best_v_q, saw_stale_q, saw_gen_q, done_q;
	logic [31:0] best_stamp_q;
	logic [15:0] best_id_q;
	logic [IW-1:0] slot_q;
	logic slot_v_q;
	rsp_t rsp_q;

	assign cmd_take  = state_q == S_IDLE && cmd_valid;
	assign rsp_valid = state_q == S_OUT;
	assign rsp       = rsp_q;

	logic [IW-1:0] cur;
	logic wr_en;
	assign cur = idx_q[IW-1:0];
	assign wr_en = state_q == S_SCAN && idx_q == (IW+1)'(TABLE_DEPTH) && slot_v_q
		&& cmd_q.kind == KIND_INSERT;

	always_ff @(posedge clk) begin
		rd_start_q <= start_m[cur];
		rd_end_q   <= end_m[cur];
		rd_gen_q   <= gen_m[cur];
		rd_stamp_q <= stamp_m[cur];
		rd_id_q    <= id_m[cur];
		if (wr_en) begin
			start_m[slot_q] <= cmd_q.lo;
			end_m[slot_q]   <= cmd_q.hi;
			gen_m[slot_q]   <= cmd_q.gen;
			id_m[slot_q]    <= cmd_q.hnd;
			stamp_m[slot_q] <= ins_cnt_q;
		end
	end

	logic e_v, e_s, smatch;
	assign e_v = valid_q[rd_idx_q];
	assign e_s = stale_q[rd_idx_q];
	assign smatch = e_v && rd_start_q == cmd_q.lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			stale_q   <= '0;
			count_q   <= '0;
			ins_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						idx_q       <= '0;
						best_v_q    <= 1'b0;
						saw_stale_q <= 1'b0;
						saw_gen_q   <= 1'b0;
						slot_v_q    <= 1'b0;
						done_q      <= 1'b0;
						state_q     <= S_RD;
					end
				end
				S_RD: begin
					rd_idx_q <= cur;
					idx_q    <= idx_q + 1'b1;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q != (IW+1)'(TABLE_DEPTH) || rd_idx_q != cur) begin
						case (cmd_q.kind)
							KIND_INSERT: if (!e_v && !slot_v_q) begin
								slot_v_q <= 1'b1;
								slot_q   <= rd_idx_q;
							end
							KIND_LOOKUP: if (smatch) begin
								if (e_s) saw_stale_q <= 1'b1;
								else if (rd_gen_q != cmd_q.gen) saw_gen_q <= 1'b1;
								else if (!best_v_q || rd_stamp_q >= best_stamp_q) begin
									best_v_q     <= 1'b1;
									best_stamp_q <= rd_stamp_q;
									best_id_q    <= rd_id_q;
								end
							end
							KIND_INV_ALL: if (e_v) stale_q[rd_idx_q] <= 1'b1;
							KIND_INV_RNG: if (e_v && cmd_q.lo < cmd_q.hi
								&& rd_start_q < cmd_q.hi && rd_end_q > cmd_q.lo)
								stale_q[rd_idx_q] <= 1'b1;
							KIND_FREE: if (e_v && !done_q && rd_id_q == cmd_q.hnd) begin
								done_q <= 1'b1;
								valid_q[rd_idx_q] <= 1'b0;
								stale_q[rd_idx_q] <= 1'b0;
								count_q <= count_q - 1'b1;
							end
							default: ;
						endcase
					end
					if (idx_q == (IW+1)'(TABLE_DEPTH)) begin
						if (rd_idx_q == cur) begin
							// last entry already folded in; finish
							if (wr_en) begin
								valid_q[slot_q] <= 1'b1;
								stale_q[slot_q] <= 1'b0;
								count_q   <= count_q + 1'b1;
								ins_cnt_q <= ins_cnt_q + 1'b1;
							end
							state_q <= S_OUT;
						end else begin
							rd_idx_q <= cur;
						end
					end else begin
						rd_idx_q <= cur;
						idx_q    <= idx_q + 1'b1;
					end
				end
				S_OUT: if (rsp_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [CW-1:0] cnt_next;
	always_comb begin
		cnt_next = count_q;
		if (wr_en) cnt_next = count_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && idx_q == (IW+1)'(TABLE_DEPTH) && rd_idx_q == cur) begin
			rsp_q.lookup_result <= RES_MISS_NONE;
			rsp_q.found_handle  <= '0;
			rsp_q.status        <= ST_OK;
			rsp_q.block_count   <= 7'(cnt_next);
			if (cmd_q.kind == KIND_LOOKUP) begin
				if (best_v_q) begin
					rsp_q.lookup_result <= RES_HIT;
					rsp_q.found_handle  <= best_id_q;
				end else if (saw_stale_q) rsp_q.lookup_result <= RES_MISS_STALE;
				else if (saw_gen_q) rsp_q.lookup_result <= RES_MISS_GEN;
			end
			if (cmd_q.kind == KIND_INSERT && !slot_v_q) rsp_q.status <= ST_FULL;
			if (cmd_q.kind == KIND_FREE && !done_q) rsp_q.status <= ST_NO_HANDLE;
		end
	end
endmodule

/* rtl/tblt_out.sv */
module tblt_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rsp_valid,
	output logic           rsp_take,
	input  tblt_pkg::rsp_t rsp,
	output logic           empty,
	input  logic           pop,
	output logic [1:0]     lookup_result,
	output logic [15:0]    found_handle,
	output logic [1:0]     status,
	output logic [6:0]     block_count
);
	import tblt_pkg::*;

	rsp_t out_q;
	logic full_q;

	assign rsp_take = rsp_valid && (!full_q || pop);
	assign empty    = !full_q;
	assign lookup_result = out_q.lookup_result;
	assign found_handle  = out_q.found_handle;
	assign status        = out_q.status;
	assign block_count   = out_q.block_count;

	always_ff @(posedge clk) begin
		if (rsp_take) out_q <= rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (rsp_take) begin
			full_q <= 1'b1;
		end else if (pop) begin
			full_q <= 1'b0;
		end
	end
endmodule

/* rtl/translated_block_lookup_table.sv */
// Each command is handled by a sequential scan of the table, one entry per cycle, before its result is ready.
// The scan takes one command at a time; the next is taken only after the result has been handed on.
// A two-deep command queue and a result register decouple both sides from the scan.
// Reset (arst_n low) clears all valid and stale marks, the count and the insert stamp.
module translated_block_lookup_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int GEN_BITS    = 32,
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [63:0] address_low,
	input  logic [63:0] address_high,
	input  logic [31:0] generation,
	input  logic [15:0] handle,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  lookup_result,
	output logic [15:0] found_handle,
	output logic [1:0]  status,
	output logic [6:0]  block_count
);
	import tblt_pkg::*;

	cmd_t cmd;
	rsp_t rsp;
	logic cmd_valid, cmd_take, rsp_valid, rsp_take;

	tblt_front #(.GEN_BITS(GEN_BITS), .HANDLE_BITS(HANDLE_BITS)) u_front (
		.clk, .arst_n, .push, .full, .kind, .address_low, .address_high,
		.generation, .handle, .cmd_valid, .cmd_take, .cmd
	);

	tblt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd, .rsp_valid, .rsp_take, .rsp
	);

	tblt_out u_out (
		.clk, .arst_n, .rsp_valid, .rsp_take, .rsp, .empty, .pop,
		.lookup_result, .found_handle, .status, .block_count
	);
endmodule

/* dv/tblt_checker.sv */
module tblt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [2:0]  kind,
	input  logic [63:0] address_low,
	input  logic [63:0] address_high,
	input  logic [31:0] generation,
	input  logic [15:0] handle,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  lookup_result,
	input  logic [15:0] found_handle,
	input  logic [1:0]  status,
	input  logic [6:0]  block_count,
	output int          fail_count,
	output int          pending
);
	import tblt_pkg::*;

	localparam int DEPTH = 64;

	bit          slot_valid [DEPTH];
	bit          slot_stale [DEPTH];
	bit [63:0]   slot_start [DEPTH];
	bit [63:0]   slot_end   [DEPTH];
	bit [31:0]   slot_gen   [DEPTH];
	bit [15:0]   slot_id    [DEPTH];
	bit [31:0]   slot_stamp [DEPTH];
	bit [31:0]   stamp_next;
	rsp_t        expected_q [$];

	initial fail_count = 0;
	assign pending = expected_q.size();

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("%0t: %s got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic rsp_t table_op(input logic [2:0] k, input logic [63:0] lo,
			input logic [63:0] hi, input logic [31:0] g, input logic [15:0] h);
		rsp_t r;
		int slot;
		int best;
		bit saw_stale;
		bit saw_gen;
		int n;
		r = '0;
		r.lookup_result = RES_MISS_NONE;
		r.status = ST_OK;
		slot = -1;
		best = -1;
		saw_stale = 0;
		saw_gen = 0;
		n = 0;
		case (k)
			KIND_INSERT: begin
				for (int i = 0; i < DEPTH; i++)
					if (!slot_valid[i] && slot < 0) slot = i;
				if (slot < 0) r.status = ST_FULL;
				else begin
					slot_valid[slot] = 1;
					slot_stale[slot] = 0;
					slot_start[slot] = lo;
					slot_end[slot] = hi;
					slot_gen[slot] = g;
					slot_id[slot] = h;
					slot_stamp[slot] = stamp_next;
					stamp_next++;
				end
			end
			KIND_LOOKUP: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (!slot_valid[i] || slot_start[i] != lo) continue;
					if (slot_stale[i]) begin saw_stale = 1; continue; end
					if (slot_gen[i] != g) begin saw_gen = 1; continue; end
					if (best < 0 || slot_stamp[i] >= slot_stamp[best]) best = i;
				end
				if (best >= 0) begin
					r.lookup_result = RES_HIT;
					r.found_handle = slot_id[best];
				end else if (saw_stale) r.lookup_result = RES_MISS_STALE;
				else if (saw_gen) r.lookup_result = RES_MISS_GEN;
			end
			KIND_INV_ALL: begin
				for (int i = 0; i < DEPTH; i++)
					if (slot_valid[i]) slot_stale[i] = 1;
			end
			KIND_INV_RNG: begin
				if (lo < hi)
					for (int i = 0; i < DEPTH; i++)
						if (slot_valid[i] && slot_start[i] < hi && slot_end[i] > lo)
							slot_stale[i] = 1;
			end
			KIND_FREE: begin
				r.status = ST_NO_HANDLE;
				for (int i = 0; i < DEPTH; i++)
					if (slot_valid[i] && slot_id[i] == h && r.status != ST_OK) begin
						slot_valid[i] = 0;
						slot_stale[i] = 0;
						r.status = ST_OK;
					end
			end
			default: ;
		endcase
		for (int i = 0; i < DEPTH; i++) n += int'(slot_valid[i]);
		r.block_count = n[6:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t w;
		if (!arst_n) begin
			foreach (slot_valid[i]) begin
				slot_valid[i] = 0;
				slot_stale[i] = 0;
			end
			stamp_next = 0;
			expected_q.delete();
		end else begin
			if (push && !full)
				expected_q.push_back(table_op(kind, address_low, address_high, generation, handle));
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					fail_count++;
				end else begin
					w = expected_q.pop_front();
					if (lookup_result !== w.lookup_result)
						report("lookup_result", 16'(lookup_result), 16'(w.lookup_result));
					if (found_handle !== w.found_handle)
						report("found_handle", found_handle, w.found_handle);
					if (status !== w.status) report("status", 16'(status), 16'(w.status));
					if (block_count !== w.block_count)
						report("block_count", 16'(block_count), 16'(w.block_count));
				end
			end
		end
	end
endmodule

/* dv/tb_top.sv */
module tb_top;
	import tblt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  kind;
	logic [63:0] address_low;
	logic [63:0] address_high;
	logic [31:0] generation;
	logic [15:0] handle;
	logic        empty;
	logic        pop;
	logic [1:0]  lookup_result;
	logic [15:0] found_handle;
	logic [1:0]  status;
	logic [6:0]  block_count;
	int          fail_count;
	int          pending;
	int          cycles;
	bit          hold_off;
	bit          stim_done;

	logic [63:0] addr_pool [8];
	logic [15:0] hnd_pool [8];

	translated_block_lookup_table dut (.*);
	tblt_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("translated_block_lookup_table: mismatch");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input logic [2:0] k, input logic [63:0] lo, input logic [63:0] hi,
			input logic [31:0] g, input logic [15:0] h);
		push <= 1;
		kind <= k;
		address_low <= lo;
		address_high <= hi;
		generation <= g;
		handle <= h;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) :
			(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
		if (n > 0) begin
			push <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	initial begin
		logic [2:0] k;
		logic [63:0] lo;
		logic [63:0] hi;
		push = 0;
		kind = '0;
		address_low = '0;
		address_high = '0;
		generation = '0;
		handle = '0;
		stim_done = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send(KIND_LOOKUP, '0, '0, '0, '0);
		send(KIND_FREE, '0, '0, '0, 16'hffff);
		send(KIND_INSERT, 64'h10, 64'h20, 32'd1, 16'd1);
		send(KIND_INSERT, 64'h10, 64'h30, 32'd1, 16'd2);
		send(KIND_LOOKUP, 64'h10, '0, 32'd1, '0);
		send(KIND_LOOKUP, 64'h10, '0, 32'd2, '0);
		send(KIND_INSERT, '1, '0, '1, '1);
		send(KIND_INV_RNG, '1, '0, '0, '0);
		send(KIND_INV_RNG, 64'h20, 64'h20, '0, '0);
		send(KIND_INV_RNG, 64'h15, 64'h16, '0, '0);
		send(KIND_LOOKUP, 64'h10, '0, 32'd1, '0);
		send(KIND_LOOKUP, '1, '0, '1, '0);
		send(KIND_INV_ALL, '0, '0, '0, '0);
		send(KIND_LOOKUP, '1, '0, '1, '0);
		send(3'd5, '1, '1, '1, '1);
		send(3'd7, '0, '0, '0, '0);
		send(3'd6, '0, '0, '0, '0);
		send(KIND_FREE, '0, '0, '0, 16'd1);
		send(KIND_FREE, '0, '0, '0, '1);
		for (int i = 0; i < 8; i++) begin
			addr_pool[i] = rand64();
			hnd_pool[i] = 16'($urandom);
		end
		for (int i = 0; i < 1830; i++) begin
			lo = ($urandom_range(0, 3) == 0) ? rand64() : addr_pool[$urandom_range(0, 7)];
			hi = ($urandom_range(0, 1) == 0) ? lo + $urandom_range(0, 4096) : rand64();
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: k = KIND_INSERT;
				7, 8, 9, 10, 11, 12: k = KIND_LOOKUP;
				13: k = KIND_INV_ALL;
				14, 15: k = KIND_INV_RNG;
				16, 17, 18: k = KIND_FREE;
				default: k = 3'($urandom_range(5, 7));
			endcase
			if (k == KIND_INV_RNG && $urandom_range(0, 1) == 0) begin
				hi = lo + $urandom_range(1, 64);
				lo = lo - $urandom_range(0, 64);
			end
			send(k, lo, hi, ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : hnd_pool[$urandom_range(0, 7)]);
			gap();
		end
		push <= 0;
		stim_done = 1;
	end

	initial begin
		hold_off = 0;
		wait (arst_n);
		repeat (400) @(negedge clk);
		hold_off = 1;
		repeat (1500) @(negedge clk);
		hold_off = 0;
	end

	initial begin
		int n;
		pop = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) pop <= 0;
			else if ($urandom_range(0, 29) == 0) begin
				pop <= 0;
				n = $urandom_range(20, 150);
				repeat (n) @(negedge clk);
			end else pop <= ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		wait (stim_done);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("translated_block_lookup_table: match");
		else
			$display("translated_block_lookup_table: mismatch");
		$finish;
	end
endmodule
